FILE: rtl/core/unipolar_stepper_sequencer_macros.svh
`ifndef UNIPOLAR_STEPPER_SEQUENCER_MACROS_SVH
`define UNIPOLAR_STEPPER_SEQUENCER_MACROS_SVH

// Clocked assertion on clk_i, masked while rst_ni is low.
`define USS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define USS_ASSERT_IMPL(lbl, ante, cons, msg) \
  `USS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define USS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `USS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/uss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uss_pkg;

  localparam int unsigned TICK_RATE_HZ_DEF = 1000000;

  localparam int unsigned STEP_W   = 24;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned COIL_W   = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
  localparam logic [RATE_W-1:0]   DEF_SPEED_RST = 16'd100;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;
  localparam logic [1:0] OP_MOVE    = 2'd3;

  // drive modes
  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;
  // no sequence: coils and phase hold
  localparam logic [1:0] MODE_NONE = 2'd3;

  // configuration register indexes
  localparam logic CFG_DRIVE_MODE    = 1'b0;
  localparam logic CFG_DEFAULT_SPEED = 1'b1;

  localparam logic [COIL_W-1:0] WAVE_PAT [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [COIL_W-1:0] FULL_PAT [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [COIL_W-1:0] HALF_PAT [8] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    logic exec;         // apply the accepted beat to the state
    logic div_start;    // accepted move: latch count, kick off the divider
    logic load_period;  // divider finished: load period and go busy
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_go;      // move on the input would be taken
    logic div_done;
  } ctrl_sts_t;

  function automatic logic [COIL_W-1:0] coil_pattern(logic [1:0] mode,
                                                     logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    pat = '0;
    case (mode)
      MODE_WAVE: pat = WAVE_PAT[ph[1:0]];
      MODE_FULL: pat = FULL_PAT[ph[1:0]];
      MODE_HALF: pat = HALF_PAT[ph];
      default:   pat = '0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/uss_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring divider: TICK_RATE_HZ / divisor, one quotient bit
// per cycle, result clamped to [1, PERIOD_MAX].
module uss_div
  import uss_pkg::*;
#(
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  [RATE_W-1:0]   divisor_i,
  output logic                done_o,
  output logic [PERIOD_W-1:0] period_o
);

  localparam int unsigned NUM_W = $clog2(TICK_RATE_HZ + 1);
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam int unsigned EXT_W = (NUM_W > PERIOD_W) ? NUM_W : PERIOD_W + 1;
  localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(TICK_RATE_HZ);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;

  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              fits;
  logic [EXT_W-1:0]  quo_ext;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = NUMERATOR;
      quo_d = '0;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      quo_d = {quo_q[NUM_W-2:0], fits};
      // remainder stays below the divisor, so it fits RATE_W bits
      rem_d = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      if (cnt_q == LAST_CNT) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quo_ext = EXT_W'(quo_q);
  assign done_o  = done_q;

  always_comb begin
    if (quo_ext > EXT_W'(PERIOD_MAX)) begin
      period_o = PERIOD_MAX;
    end else if (quo_ext == '0) begin
      period_o = PERIOD_W'(1);
    end else begin
      period_o = quo_ext[PERIOD_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/uss_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module uss_dp
  import uss_pkg::*;
#(
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output ctrl_sts_t                sts_o,
  input  wire  [1:0]               operation_i,
  input  wire  signed [STEP_W-1:0] step_count_i,
  input  wire  [RATE_W-1:0]        steps_per_second_i,
  input  wire                      cfg_valid_i,
  input  wire                      cfg_index_i,
  input  wire  [RATE_W-1:0]        cfg_data_i,
  output logic [COIL_W-1:0]        coils_o,
  output logic                     busy_o,
  output logic                     enabled_o,
  output logic [PHASE_W-1:0]       phase_o
);

  logic [1:0]          mode_q, mode_d;
  logic [RATE_W-1:0]   dspeed_q, dspeed_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                en_q, en_d;
  logic                fwd_q, fwd_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [PERIOD_W-1:0] cdown_q, cdown_d;
  logic                busy_q, busy_d;
  logic [COIL_W-1:0]   coil_q, coil_d;

  logic [RATE_W-1:0]   rate;
  logic                div_done;
  logic [PERIOD_W-1:0] div_period;
  logic [PHASE_W-1:0]  phase_adv;
  logic [STEP_W-1:0]   steps_dec;
  logic [STEP_W-1:0]   steps_abs;
  logic                in_seq;

  always_comb begin
    rate = (steps_per_second_i != '0) ? steps_per_second_i : dspeed_q;
    if (rate == '0) begin
      rate = RATE_W'(1);
    end
  end

  uss_div #(
    .TICK_RATE_HZ(TICK_RATE_HZ)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .divisor_i(rate),
    .done_o   (div_done),
    .period_o (div_period)
  );

  assign sts_o.move_go  = (operation_i == OP_MOVE) && en_q && !busy_q;
  assign sts_o.div_done = div_done;

  // next phase one step along the sequence; 4-long modes fold 4..7 back in
  always_comb begin
    if (mode_q == MODE_HALF) begin
      phase_adv = fwd_q ? phase_q + 1'b1 : phase_q - 1'b1;
    end else begin
      phase_adv = {1'b0, fwd_q ? phase_q[1:0] + 2'd1 : phase_q[1:0] - 2'd1};
    end
  end

  assign steps_dec = steps_q - 1'b1;
  assign steps_abs = step_count_i[STEP_W-1] ? STEP_W'(-step_count_i)
                                            : STEP_W'(step_count_i);
  assign in_seq = (mode_q == MODE_HALF) ||
                  (((mode_q == MODE_WAVE) || (mode_q == MODE_FULL)) && !phase_q[2]);

  always_comb begin
    mode_d   = mode_q;
    dspeed_d = dspeed_q;
    phase_d  = phase_q;
    en_d     = en_q;
    fwd_d    = fwd_q;
    steps_d  = steps_q;
    period_d = period_q;
    cdown_d  = cdown_q;
    busy_d   = busy_q;
    coil_d   = coil_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DRIVE_MODE:    mode_d   = cfg_data_i[1:0];
        CFG_DEFAULT_SPEED: dspeed_d = cfg_data_i;
        default:           mode_d   = mode_q;
      endcase
    end

    if (cmd_i.exec) begin
      case (operation_i)
        OP_TICK: begin
          if (busy_q) begin
            if (cdown_q <= PERIOD_W'(1)) begin
              if (en_q && (steps_q != '0)) begin
                steps_d = steps_dec;
                if (mode_q != MODE_NONE) begin
                  phase_d = phase_adv;
                  coil_d  = coil_pattern(mode_q, phase_adv);
                end
                if (steps_dec != '0) begin
                  cdown_d = period_q;
                end else begin
                  busy_d  = 1'b0;
                  cdown_d = '0;
                end
              end else begin
                steps_d = '0;
                busy_d  = 1'b0;
                cdown_d = '0;
              end
            end else begin
              cdown_d = cdown_q - 1'b1;
            end
          end
        end
        OP_ENABLE: begin
          if (in_seq) begin
            coil_d = coil_pattern(mode_q, phase_q);
          end
          en_d = 1'b1;
        end
        OP_DISABLE: begin
          coil_d  = '0;
          en_d    = 1'b0;
          busy_d  = 1'b0;
          steps_d = '0;
          cdown_d = '0;
        end
        OP_MOVE: begin
          if (cmd_i.div_start) begin
            fwd_d   = !step_count_i[STEP_W-1];
            steps_d = steps_abs;
          end
        end
        default: busy_d = busy_q;
      endcase
    end

    if (cmd_i.load_period) begin
      period_d = div_period;
      cdown_d  = div_period;
      busy_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WAVE;
      dspeed_q <= DEF_SPEED_RST;
      phase_q  <= '0;
      en_q     <= 1'b0;
      fwd_q    <= 1'b0;
      steps_q  <= '0;
      period_q <= '0;
      cdown_q  <= '0;
      busy_q   <= 1'b0;
      coil_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      dspeed_q <= dspeed_d;
      phase_q  <= phase_d;
      en_q     <= en_d;
      fwd_q    <= fwd_d;
      steps_q  <= steps_d;
      period_q <= period_d;
      cdown_q  <= cdown_d;
      busy_q   <= busy_d;
      coil_q   <= coil_d;
    end
  end

  assign coils_o   = coil_q;
  assign busy_o    = busy_q;
  assign enabled_o = en_q;
  assign phase_o   = phase_q;

endmodule

`default_nettype wire

FILE: rtl/core/uss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module uss_ctrl
  import uss_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_q, state_d;
  logic ovld_q, ovld_d;
  logic accept;

  // the state registers are the result; a new beat only enters once the
  // pending one leaves
  assign in_ready_o = (state_q == ST_IDLE) && (!ovld_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    ovld_d            = ovld_q && !out_ready_i;
    cmd_o.exec        = accept;
    cmd_o.div_start   = 1'b0;
    cmd_o.load_period = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.move_go) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            ovld_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.load_period = 1'b1;
          ovld_d            = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;

endmodule

`default_nettype wire

FILE: rtl/core/unipolar_stepper_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Unipolar stepper sequencer: tick, enable, disable and move commands drive
// four coils in wave, full-step or half-step order (or hold them in the
// no-sequence mode); every command returns one result beat with coils,
// busy, enabled and phase. Tick, enable, disable and a refused move give a
// registered result, and one can enter every cycle as long as results are
// taken. An accepted move computes its period with a bit-serial restoring
// divider, one quotient bit per cycle; its result appears when the divider
// is done, and no beat is taken meanwhile. The configuration port is always
// ready; write it only while the block is idle. No clearing pass after reset.
module unipolar_stepper_sequencer
  import uss_pkg::*;
#(
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire  [1:0]               operation_i,
  input  wire  signed [STEP_W-1:0] step_count_i,
  input  wire  [RATE_W-1:0]        steps_per_second_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [COIL_W-1:0]        coils_o,
  output logic                     busy_res_o,
  output logic                     enabled_now_o,
  output logic [PHASE_W-1:0]       phase_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire                      cfg_index_i,
  input  wire  [RATE_W-1:0]        cfg_data_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  uss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uss_dp #(
    .TICK_RATE_HZ(TICK_RATE_HZ)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .step_count_i      (step_count_i),
    .steps_per_second_i(steps_per_second_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .coils_o           (coils_o),
    .busy_o            (busy_res_o),
    .enabled_o         (enabled_now_o),
    .phase_o           (phase_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/uss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "unipolar_stepper_sequencer_macros.svh"

module uss_checker
  import uss_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire [1:0]           operation_i,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input wire [COIL_W-1:0]    coils_o,
  input wire                 busy_res_o,
  input wire                 enabled_now_o
);

  `USS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o,
    "result beat dropped before it was taken")

  `USS_ASSERT_IMPL(a_no_overrun, out_valid_o && !out_ready_i, !in_ready_o,
    "input taken while a result is stalled")

  `USS_ASSERT_IMPL(a_disabled_quiet, out_valid_o && !enabled_now_o,
    (coils_o == '0) && !busy_res_o, "coils driven or busy while disabled")

  `USS_ASSERT_NEXT(a_disable_result,
    in_valid_i && in_ready_o && (operation_i == OP_DISABLE),
    out_valid_o && !enabled_now_o && !busy_res_o,
    "disable did not report an idle, disabled driver")

endmodule

bind unipolar_stepper_sequencer uss_checker u_uss_checker (.*);

`default_nettype wire
